@@ design/qmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// qmhq_pkg
// Shared types and constants of the quaternary min-heap queue.
// ----------------------------------------------------------------------------
package qmhq_pkg;

  localparam int ROW_W  = 16;
  localparam int COL_W  = 16;
  localparam int ELEV_W = 32;
  localparam int POS_W  = ROW_W + COL_W;
  localparam int STAT_W = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_INS_FULL  = 2'd2
  } status_t;

endpackage

@@ design/qmhq_if.sv @@
// ----------------------------------------------------------------------------
// qmhq_if
// Valid/ready channels of the quaternary min-heap queue: command and result.
// ----------------------------------------------------------------------------
interface qmhq_req_if
  import qmhq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [ELEV_W-1:0] elevation;

  modport source (output valid, cmd, row, col, elevation, input ready);
  modport sink   (input valid, cmd, row, col, elevation, output ready);
endinterface

interface qmhq_rsp_if
  import qmhq_pkg::*;
#(
  parameter int CNT_W = 17
) ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic signed [ELEV_W-1:0] out_elevation;
  logic [CNT_W-1:0]         occupancy;

  modport source (output valid, status, out_row, out_col, out_elevation, occupancy,
                  input ready);
  modport sink   (input valid, status, out_row, out_col, out_elevation, occupancy,
                  output ready);
endinterface

@@ design/quaternary_min_heap_queue_core.sv @@
// ----------------------------------------------------------------------------
// quaternary_min_heap_queue_core
// 4-ary min-heap of raster points held in one single-port-read, single-port-
// write synchronous memory; inserts sift up, pops sift the last entry down.
// ----------------------------------------------------------------------------
// Sequence: an insert climbs one level per parent read and compare, moving
//   each larger parent down; a pop reads the root and the last entry, then
//   per level compared does one memory read per child; errors skip the memory.
// Throughput: one transaction at a time; the next is taken once the result
//   sits in the output register, which may still be waiting to be taken.
// Reset: heap empty, sequence counter zero; memory contents are not cleared.
module quaternary_min_heap_queue_core
  import qmhq_pkg::*;
#(
  parameter int HEAP_DEPTH = 65536,
  parameter int SEQ_WIDTH  = 32
) (
  input  logic       clk,
  input  logic       rst,
  qmhq_req_if.sink   req,
  qmhq_rsp_if.source rsp
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = ELEV_W + SEQ_WIDTH;
  localparam int EW = KW + POS_W;
  localparam int XW = CW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_POP_GOT,
    S_DN_START,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t state;

  logic [EW-1:0] mem [HEAP_DEPTH];
  logic [EW-1:0] rdata;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  logic [CW-1:0]        count;
  logic [SEQ_WIDTH-1:0] seq;
  logic [CW-1:0]        slot;
  logic [KW-1:0]        new_key;
  logic [POS_W-1:0]     new_pos;
  logic [EW-1:0]        last;
  logic [EW-1:0]        best;
  logic [CW-1:0]        best_slot;
  logic                 best_set;
  logic [CW-1:0]        kid;
  logic [CW-1:0]        k;

  logic [STAT_W-1:0]    res_status;
  logic [POS_W-1:0]     res_pos;
  logic [ELEV_W-1:0]    res_elev;

  logic                 out_valid;

  logic [CW-1:0]        parent;
  logic [XW-1:0]        kid_ext;
  logic                 kid_ok;
  logic [CW-1:0]        k_next;
  logic                 more;
  logic                 take_rd;
  logic [EW-1:0]        cand;
  logic [CW-1:0]        cand_slot;
  logic                 last_wins;
  logic                 up_move;

  function automatic logic [KW-1:0] key_of(input logic [EW-1:0] e);
    return e[EW-1 -: KW];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] s);
    logic [CW-1:0] a;
    a = s - CW'(1);
    return a[AW-1:0];
  endfunction

  assign parent  = CW'(((slot - CW'(2)) >> 2) + CW'(1));
  assign kid_ext = {slot, 2'b00} - XW'(2);
  assign kid_ok  = kid_ext < {2'b00, count};
  assign k_next  = k + CW'(1);
  assign more    = (k_next < count) && ((k - kid) < CW'(3));
  assign take_rd = !best_set || (key_of(rdata) < key_of(best));
  assign cand      = take_rd ? rdata : best;
  assign cand_slot = take_rd ? k : best_slot;
  assign last_wins = key_of(last) < key_of(cand);
  assign up_move   = new_key < key_of(rdata);

  // Memory port control, driven from the current state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = addr_of(slot);
    wr_data = {new_key, new_pos};
    case (state)
      S_UP_RD: begin
        if (slot == CW'(1)) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = addr_of(parent);
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (up_move) begin
          wr_data = rdata;
        end
      end
      S_POP_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_POP_LAST: begin
        rd_en   = 1'b1;
        rd_addr = addr_of(count);
      end
      S_DN_START: begin
        if (kid_ok) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(kid_ext[CW-1:0]);
        end else begin
          wr_en   = 1'b1;
          wr_data = last;
        end
      end
      S_DN_CMP: begin
        if (more) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(k_next);
        end else begin
          wr_en   = 1'b1;
          wr_data = last_wins ? last : cand;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      seq       <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result; FIN reloads the register itself
      if (out_valid && rsp.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_status <= STAT_OK;
            res_pos    <= '0;
            res_elev   <= '0;
            if (req.cmd == CMD_INSERT) begin
              if (count == CW'(HEAP_DEPTH)) begin
                res_status <= STAT_INS_FULL;
                state      <= S_FIN;
              end else begin
                new_key <= {req.elevation ^ {1'b1, {(ELEV_W-1){1'b0}}}, seq};
                new_pos <= {req.row, req.col};
                seq     <= seq + SEQ_WIDTH'(1);
                count   <= count + CW'(1);
                slot    <= count + CW'(1);
                state   <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= STAT_POP_EMPTY;
                state      <= S_FIN;
              end else begin
                slot  <= CW'(1);
                state <= S_POP_ROOT;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (slot == CW'(1)) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          // climb while the new key beats its parent
          if (up_move) begin
            slot  <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_POP_ROOT: begin
          state <= S_POP_LAST;
        end
        S_POP_LAST: begin
          res_pos  <= rdata[POS_W-1:0];
          res_elev <= rdata[EW-1 -: ELEV_W] ^ {1'b1, {(ELEV_W-1){1'b0}}};
          state    <= S_POP_GOT;
        end
        S_POP_GOT: begin
          last <= rdata;
          if (count == CW'(1)) begin
            count <= '0;
            state <= S_FIN;
          end else begin
            state <= S_DN_START;
          end
        end
        S_DN_START: begin
          if (kid_ok) begin
            kid      <= kid_ext[CW-1:0];
            k        <= kid_ext[CW-1:0];
            best_set <= 1'b0;
            state    <= S_DN_CMP;
          end else begin
            count <= count - CW'(1);
            state <= S_FIN;
          end
        end
        S_DN_CMP: begin
          best      <= cand;
          best_slot <= cand_slot;
          best_set  <= 1'b1;
          if (more) begin
            k <= k_next;
          end else if (last_wins) begin
            count <= count - CW'(1);
            state <= S_FIN;
          end else begin
            // move the smallest child up and descend into its slot
            slot  <= cand_slot;
            state <= S_DN_START;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            rsp.status        <= res_status;
            rsp.out_row       <= res_pos[POS_W-1 -: ROW_W];
            rsp.out_col       <= res_pos[COL_W-1:0];
            rsp.out_elevation <= res_elev;
            rsp.occupancy     <= count;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ tb/tb_quaternary_min_heap_queue_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternary_min_heap_queue_core
// Drives insert and pop commands into the 4-ary min-heap queue and checks
// every result against a shadow heap kept in the bench. The directed corners
// come first. Random grow/drain sequences follow under changing
// back-pressure.
// ----------------------------------------------------------------------------
module tb_quaternary_min_heap_queue_core;
  import qmhq_pkg::*;

  localparam int unsigned DEPTH            = 65536;
  localparam int unsigned SEQ_BITS         = 32;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES    = 80;

  typedef struct packed {
    cmd_t                     cmd;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [ELEV_W-1:0] elevation;
  } heap_cmd_t;

  typedef struct packed {
    status_t                  status;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [ELEV_W-1:0] elevation;
    logic [16:0]              occupancy;
  } heap_answer_t;

  logic clk;
  logic rst;

  qmhq_req_if          req ();
  qmhq_rsp_if #(.CNT_W(17)) rsp ();

  quaternary_min_heap_queue_core #(
    .HEAP_DEPTH(DEPTH),
    .SEQ_WIDTH (SEQ_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow heap: key is {elevation with sign bit flipped, stamp}, point is {row, col}
  logic [63:0]         heap_key   [1:DEPTH];
  logic [31:0]         heap_point [1:DEPTH];
  int unsigned         shadow_count;
  logic [SEQ_BITS-1:0] seq_stamp;

  heap_answer_t pending_answers[$];
  int unsigned  fault_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  logic         long_hold_req;
  logic         long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

  // Apply one accepted command to the shadow heap and return its result
  function automatic heap_answer_t serve_command(heap_cmd_t c);
    heap_answer_t a;
    logic [63:0]  k;
    logic [63:0]  best_k;
    logic [31:0]  p;
    int unsigned  slot;
    int unsigned  up;
    int unsigned  n;
    int unsigned  kid;
    int unsigned  best;
    int unsigned  j;
    a = '0;
    a.status = STAT_OK;
    if (c.cmd == CMD_INSERT) begin
      if (shadow_count >= DEPTH) begin
        a.status = STAT_INS_FULL;
      end else begin
        k = {c.elevation ^ 32'h8000_0000, 32'(seq_stamp)};
        p = {c.row, c.col};
        seq_stamp = seq_stamp + 1'b1;
        shadow_count++;
        slot = shadow_count;
        while (slot > 1) begin
          up = ((slot - 2) >> 2) + 1;
          if (k < heap_key[up]) begin
            heap_key[slot]   = heap_key[up];
            heap_point[slot] = heap_point[up];
            slot = up;
          end else begin
            break;
          end
        end
        heap_key[slot]   = k;
        heap_point[slot] = p;
      end
    end else if (shadow_count == 0) begin
      a.status = STAT_POP_EMPTY;
    end else begin
      n = shadow_count;
      a.row       = heap_point[1][31:16];
      a.col       = heap_point[1][15:0];
      a.elevation = heap_key[1][63:32] ^ 32'h8000_0000;
      k    = heap_key[n];
      p    = heap_point[n];
      slot = 1;
      if (n > 1) begin
        kid = 4 * slot - 2;
        while (kid < n) begin
          best   = kid;
          best_k = heap_key[kid];
          for (j = kid + 1; j < n && j < kid + 4; j++) begin
            if (heap_key[j] < best_k) begin
              best   = j;
              best_k = heap_key[j];
            end
          end
          // equal keys: the moved entry descends past the child
          if (k < best_k) break;
          heap_key[slot]   = best_k;
          heap_point[slot] = heap_point[best];
          slot = best;
          kid  = 4 * slot - 2;
        end
        heap_key[slot]   = k;
        heap_point[slot] = p;
      end
      shadow_count = n - 1;
    end
    a.occupancy = shadow_count[16:0];
    return a;
  endfunction

  function automatic heap_cmd_t point(cmd_t op, logic [15:0] r, logic [15:0] c,
                                      logic signed [31:0] e);
    heap_cmd_t t;
    t.cmd       = op;
    t.row       = r;
    t.col       = c;
    t.elevation = e;
    return t;
  endfunction

  function automatic logic signed [31:0] random_elevation();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3, 4: return $signed(32'($urandom_range(5))) - 2;  // narrow pool for ties
      5:       return 32'sh8000_0000 + 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  function automatic heap_cmd_t random_point(cmd_t op);
    return point(op, 16'($urandom), 16'($urandom), random_elevation());
  endfunction

  task automatic send_command(input heap_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.cmd       <= c.cmd;
    req.row       <= c.row;
    req.col       <= c.col;
    req.elevation <= c.elevation;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_answers.push_back(serve_command(c));
  endtask

  task automatic wait_all_answered();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // Result sink: random stalls, plus one long hold on request
  initial begin
    rsp.ready      <= 1'b0;
    long_hold_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    heap_answer_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result expected none actual status %0d occupancy %0d",
                 $time, rsp.status, rsp.occupancy);
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 32'(want.status), 32'(rsp.status));
        check_field("out_row", 32'(want.row), 32'(rsp.out_row));
        check_field("out_col", 32'(want.col), 32'(rsp.out_col));
        check_field("out_elevation", 32'(want.elevation), 32'(rsp.out_elevation));
        check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
      end
    end
  end

  task automatic test_directed_corners();
    send_command(random_point(CMD_POP));   // pop on empty heap
    send_command(point(CMD_INSERT, 16'h0000, 16'h0000, 32'sd0));
    send_command(point(CMD_INSERT, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF));
    send_command(point(CMD_INSERT, 16'h0001, 16'h0002, 32'sh8000_0000));
    send_command(point(CMD_INSERT, 16'hAAAA, 16'h5555, -32'sd1));
    send_command(point(CMD_INSERT, 16'h5555, 16'hAAAA, -32'sd1));
    send_command(point(CMD_INSERT, 16'h1234, 16'h8765, 32'sd1));
    repeat (6) send_command(random_point(CMD_POP));
    send_command(random_point(CMD_POP));
    // equal elevations come out in insertion order
    for (int i = 1; i <= 5; i++) begin
      send_command(point(CMD_INSERT, 16'(i), 16'(~i), 32'sd7));
    end
    repeat (5) send_command(random_point(CMD_POP));
  endtask

  task automatic test_random_mix(input int unsigned items, input int unsigned tx_gap,
                                 input int unsigned rx_gap);
    bit          grow;
    int unsigned ceiling;
    bit          want_insert;
    send_idle_pct = tx_gap;
    recv_idle_pct = rx_gap;
    grow    = 1'b1;
    ceiling = $urandom_range(1, 120);
    repeat (items) begin
      if (grow && shadow_count >= ceiling) begin
        grow = 1'b0;
      end else if (!grow && shadow_count == 0 && $urandom_range(3) == 0) begin
        grow    = 1'b1;
        ceiling = ($urandom_range(9) == 0) ? $urandom_range(300, 700) : $urandom_range(1, 120);
      end
      want_insert = ($urandom_range(99) < 80) == grow;
      send_command(random_point(want_insert ? CMD_INSERT : CMD_POP));
    end
  endtask

  task automatic test_output_backpressure();
    wait_all_answered();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req <= 1'b1;
    // keep offering while results are held so that the input stalls
    for (int i = 0; i < 16; i++) begin
      send_command(random_point((i % 3 == 2) ? CMD_POP : CMD_INSERT));
    end
    while (!long_hold_done) @(posedge clk);
    long_hold_req <= 1'b0;
    wait_all_answered();
    repeat (4) send_command(random_point(CMD_POP));
  endtask

  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.cmd       <= CMD_INSERT;
    req.row       <= '0;
    req.col       <= '0;
    req.elevation <= '0;
    long_hold_req <= 1'b0;
    shadow_count  = 0;
    seq_stamp     = '0;
    fault_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_mix(600, 19, 74);
    test_output_backpressure();
    test_random_mix(600, 74, 19);
    test_random_mix(600, 0, 0);

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/qmhq_pkg.sv
design/qmhq_if.sv
design/quaternary_min_heap_queue_core.sv
tb/tb_quaternary_min_heap_queue_core.sv
